[rtl/core/ssrc_pkg.sv]
// Package for the sorted store with two-range count.
// Holds the store geometry, field widths and command codes; no dependencies.
package ssrc_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 2;
    localparam int HIT_W    = 11;

    typedef logic [CMD_W-1:0]         cmd_t;
    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic [CNT_W-1:0]         count_t;
    typedef logic [ADDR_W-1:0]        addr_t;

    localparam cmd_t CMD_LOAD  = 2'd0;
    localparam cmd_t CMD_QUERY = 2'd1;
    localparam cmd_t CMD_CLEAR = 2'd2;

endpackage

[rtl/core/ssrc_ifs.sv]
// Valid/ready channel interfaces for the request and response streams.
// Depends on ssrc_pkg for the payload types.
interface ssrc_req_if;
    logic                  valid;
    logic                  ready;
    ssrc_pkg::cmd_t        command;
    ssrc_pkg::word_t       value;
    ssrc_pkg::word_t       low_a;
    ssrc_pkg::word_t       high_a;
    ssrc_pkg::word_t       low_b;
    ssrc_pkg::word_t       high_b;

    modport source (output valid, command, value, low_a, high_a, low_b, high_b,
                    input ready);
    modport sink (input valid, command, value, low_a, high_a, low_b, high_b,
                  output ready);
endinterface

interface ssrc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [ssrc_pkg::HIT_W-1:0]  hit_count;
    logic                        status;

    modport source (output valid, hit_count, status, input ready);
    modport sink (input valid, hit_count, status, output ready);
endinterface

[rtl/core/ssrc_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package dependency.
module ssrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/sorted_store_two_range_count.sv]
// Top level of the sorted store with two-range count.
// Depends on ssrc_pkg, ssrc_req_if, ssrc_rsp_if and ssrc_ram.
//
//   channel  role  payload
//   req      sink  command, value, low_a, high_a, low_b, high_b
//   rsp      src   hit_count, status
//
// One item at a time. A binary search step reads the RAM (S_SRCH), then compares (S_CMP).
// A load into a non-full store searches, then shifts entries from fill-1 down to the
// insert position up one slot through the single RAM port pair and writes the value.
// A query runs four searches. Clear only zeroes the fill count.
// Reset zeroes the fill count and control state; there is no clearing pass over the store.
// The response register frees the request side while a result waits for transfer.
module sorted_store_two_range_count (
    input  logic       clk,
    input  logic       rst_n,
    ssrc_req_if.sink   req,
    ssrc_rsp_if.source rsp
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRCH  = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_INS   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]       state_reg, state_next;
    ssrc_pkg::cmd_t   cmd_reg, cmd_next;
    ssrc_pkg::word_t  value_reg, value_next;
    ssrc_pkg::word_t  low_a_reg, low_a_next;
    ssrc_pkg::word_t  high_a_reg, high_a_next;
    ssrc_pkg::word_t  low_b_reg, low_b_next;
    ssrc_pkg::word_t  high_b_reg, high_b_next;
    ssrc_pkg::count_t fill_reg, fill_next;
    ssrc_pkg::count_t lo_reg, lo_next;
    ssrc_pkg::count_t hi_reg, hi_next;
    ssrc_pkg::count_t mid_reg, mid_next;
    ssrc_pkg::count_t sa_reg, sa_next;
    ssrc_pkg::count_t ea_reg, ea_next;
    ssrc_pkg::count_t sb_reg, sb_next;
    ssrc_pkg::count_t eb_reg, eb_next;
    logic [1:0]       step_reg, step_next;
    ssrc_pkg::addr_t  rd_reg, rd_next;
    ssrc_pkg::addr_t  prev_reg, prev_next;
    logic             rd_left_reg, rd_left_next;
    logic             pend_reg, pend_next;
    logic             status_reg, status_next;
    logic             out_valid_reg, out_valid_next;
    logic [ssrc_pkg::HIT_W-1:0] out_hit_reg, out_hit_next;
    logic             out_status_reg, out_status_next;

    logic                        ram_we;
    ssrc_pkg::addr_t             ram_waddr;
    logic [ssrc_pkg::DATA_W-1:0] ram_wdata;
    ssrc_pkg::addr_t             ram_raddr;
    logic [ssrc_pkg::DATA_W-1:0] ram_rdata;

    ssrc_pkg::count_t mid;
    ssrc_pkg::word_t  key;
    logic             lower_mode;
    logic             go_right;
    logic             has_a, has_b;
    logic [ssrc_pkg::CNT_W:0] total;
    ssrc_pkg::count_t ov_s, ov_e;

    ssrc_ram #(
        .WIDTH(ssrc_pkg::DATA_W),
        .DEPTH(ssrc_pkg::CAPACITY)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        lower_mode = 1'b0;
        key        = value_reg;
        if (cmd_reg == ssrc_pkg::CMD_QUERY)
        begin
            case (step_reg)
                2'd0:    begin key = low_a_reg;  lower_mode = 1'b1; end
                2'd1:    begin key = high_a_reg; lower_mode = 1'b0; end
                2'd2:    begin key = low_b_reg;  lower_mode = 1'b1; end
                default: begin key = high_b_reg; lower_mode = 1'b0; end
            endcase
        end
    end

    assign go_right = lower_mode ? ($signed(ram_rdata) < key) : ($signed(ram_rdata) <= key);

    always_comb
    begin
        has_a = (low_a_reg <= high_a_reg) && (ea_reg > sa_reg);
        has_b = (low_b_reg <= high_b_reg) && (eb_reg > sb_reg);
        ov_s  = (sa_reg > sb_reg) ? sa_reg : sb_reg;
        ov_e  = (ea_reg < eb_reg) ? ea_reg : eb_reg;
        total = '0;
        if (has_a)
        begin
            total = total + {1'b0, ea_reg - sa_reg};
        end
        if (has_b)
        begin
            total = total + {1'b0, eb_reg - sb_reg};
        end
        if (has_a && has_b && (ov_e > ov_s))
        begin
            total = total - {1'b0, ov_e - ov_s};
        end
    end

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.hit_count = out_hit_reg;
    assign rsp.status    = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        value_next      = value_reg;
        low_a_next      = low_a_reg;
        high_a_next     = high_a_reg;
        low_b_next      = low_b_reg;
        high_b_next     = high_b_reg;
        fill_next       = fill_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        sa_next         = sa_reg;
        ea_next         = ea_reg;
        sb_next         = sb_reg;
        eb_next         = eb_reg;
        step_next       = step_reg;
        rd_next         = rd_reg;
        prev_next       = prev_reg;
        rd_left_next    = rd_left_reg;
        pend_next       = pend_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_hit_next    = out_hit_reg;
        out_status_next = out_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = prev_reg + 1'b1;
        ram_wdata       = ram_rdata;
        ram_raddr       = mid[ssrc_pkg::ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next    = req.command;
                    value_next  = req.value;
                    low_a_next  = req.low_a;
                    high_a_next = req.high_a;
                    low_b_next  = req.low_b;
                    high_b_next = req.high_b;
                    status_next = 1'b0;
                    step_next   = 2'd0;
                    lo_next     = '0;
                    hi_next     = fill_reg;
                    state_next  = S_DONE;
                    case (req.command)
                        ssrc_pkg::CMD_LOAD:
                        begin
                            if (fill_reg == ssrc_pkg::count_t'(ssrc_pkg::CAPACITY))
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SRCH;
                            end
                        end
                        ssrc_pkg::CMD_QUERY:
                        begin
                            state_next = S_SRCH;
                        end
                        ssrc_pkg::CMD_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid;
                    state_next = S_CMP;
                end
                else if (cmd_reg == ssrc_pkg::CMD_LOAD)
                begin
                    mid_next = lo_reg;
                    if (lo_reg == fill_reg)
                    begin
                        state_next = S_INS;
                    end
                    else
                    begin
                        rd_next      = ssrc_pkg::addr_t'(fill_reg - 1'b1);
                        rd_left_next = 1'b1;
                        pend_next    = 1'b0;
                        state_next   = S_SHIFT;
                    end
                end
                else
                begin
                    case (step_reg)
                        2'd0:    sa_next = lo_reg;
                        2'd1:    ea_next = lo_reg;
                        2'd2:    sb_next = lo_reg;
                        default: eb_next = lo_reg;
                    endcase
                    lo_next = '0;
                    hi_next = fill_reg;
                    if (step_reg == 2'd3)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        step_next  = step_reg + 1'b1;
                        state_next = S_SRCH;
                    end
                end
            end

            S_CMP:
            begin
                if (go_right)
                begin
                    lo_next = mid_reg + 1'b1;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH;
            end

            S_SHIFT:
            begin
                ram_we    = pend_reg;
                ram_raddr = rd_reg;
                if (rd_left_reg)
                begin
                    pend_next = 1'b1;
                    prev_next = rd_reg;
                    if (rd_reg == mid_reg[ssrc_pkg::ADDR_W-1:0])
                    begin
                        rd_left_next = 1'b0;
                    end
                    else
                    begin
                        rd_next = rd_reg - 1'b1;
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_INS;
                    end
                end
            end

            S_INS:
            begin
                ram_we     = 1'b1;
                ram_waddr  = mid_reg[ssrc_pkg::ADDR_W-1:0];
                ram_wdata  = value_reg;
                fill_next  = fill_reg + 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_hit_next    = (cmd_reg == ssrc_pkg::CMD_QUERY)
                                      ? ssrc_pkg::HIT_W'(total) : '0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            rd_left_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rd_left_reg   <= rd_left_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        value_reg      <= value_next;
        low_a_reg      <= low_a_next;
        high_a_reg     <= high_a_next;
        low_b_reg      <= low_b_next;
        high_b_reg     <= high_b_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        sa_reg         <= sa_next;
        ea_reg         <= ea_next;
        sb_reg         <= sb_next;
        eb_reg         <= eb_next;
        step_reg       <= step_next;
        rd_reg         <= rd_next;
        prev_reg       <= prev_next;
        status_reg     <= status_next;
        out_hit_reg    <= out_hit_next;
        out_status_reg <= out_status_next;
    end

endmodule
